// File: hdl/pidc_pkg.sv
package pidc_pkg;

  // Datapath widths
  localparam int ERR_W  = 33;  // exact difference of two 32-bit values
  localparam int MOP_W  = 25;  // second multiplier operand: gain or unsigned dt
  localparam int PROD_W = ERR_W + MOP_W;
  localparam int ACC_W  = 60;  // holds the sum of three products
  localparam int IDX_W  = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_D         = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

  localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic               action;
    logic signed [31:0] measured_position;
    logic signed [31:0] measured_velocity;
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic        [23:0] time_step;
  } pidc_cmd_t;

  typedef struct packed {
    logic signed [31:0] control_out;
  } pidc_res_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [31:0]      value;
  } pidc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_E,
    ST_INT_ADD,
    ST_INT_CLAMP,
    ST_MUL_KI,
    ST_SUM,
    ST_OUT
  } pidc_state_t;

  typedef enum logic [1:0] {
    MS_E_DT,
    MS_KP_PE,
    MS_KD_VE,
    MS_KI_INT
  } pidc_mul_sel_t;

  typedef struct packed {
    pidc_state_t   st;
    logic          idle;
    pidc_mul_sel_t mul_sel;
    logic          int_add;
    logic          int_clamp;
    logic          acc_load;
    logic          acc_add;
    logic          out_load;
  } pidc_ctrl_t;

  // Symmetric clamp of a wide signed value to +/- lim
  function automatic logic signed [31:0] clamp_sym(logic signed [ACC_W-1:0] v,
                                                   logic [30:0] lim);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [31:0]      r;
    hi = signed'({{(ACC_W-31){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      r = signed'({1'b0, lim});
    end else if (v < lo) begin
      r = -signed'({1'b0, lim});
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/pidc_stream_if.sv
interface pidc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/pidc_mul.sv
module pidc_mul (
  input  logic                                 clk,
  input  pidc_pkg::pidc_mul_sel_t              sel,
  input  logic signed [pidc_pkg::ERR_W-1:0]    pos_err,
  input  logic signed [pidc_pkg::ERR_W-1:0]    vel_err,
  input  logic signed [31:0]                   integral,
  input  logic        [23:0]                   dt,
  input  logic signed [23:0]                   kp,
  input  logic signed [23:0]                   kd,
  input  logic signed [23:0]                   ki,
  output logic signed [pidc_pkg::PROD_W-1:0]   prod
);
  import pidc_pkg::*;

  logic signed [ERR_W-1:0] op_a;
  logic signed [MOP_W-1:0] op_b;

  // operand select
  always_comb begin
    unique case (sel)
      MS_E_DT: begin
        op_a = pos_err;
        op_b = signed'({1'b0, dt});
      end
      MS_KP_PE: begin
        op_a = pos_err;
        op_b = MOP_W'(kp);
      end
      MS_KD_VE: begin
        op_a = vel_err;
        op_b = MOP_W'(kd);
      end
      MS_KI_INT: begin
        op_a = ERR_W'(integral);
        op_b = MOP_W'(ki);
      end
      default: begin
        op_a = pos_err;
        op_b = signed'({1'b0, dt});
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// File: hdl/pidc_seq.sv
module pidc_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 out_hold,
  output pidc_pkg::pidc_ctrl_t ctrl
);
  import pidc_pkg::*;

  pidc_state_t state;
  pidc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    unique case (state)
      ST_IDLE:      state_next = start ? ST_MUL_E : ST_IDLE;
      ST_MUL_E:     state_next = ST_INT_ADD;
      ST_INT_ADD:   state_next = ST_INT_CLAMP;
      ST_INT_CLAMP: state_next = ST_MUL_KI;
      ST_MUL_KI:    state_next = ST_SUM;
      ST_SUM:       state_next = ST_OUT;
      ST_OUT:       state_next = out_hold ? ST_OUT : ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    ctrl           = '0;
    ctrl.st        = state;
    ctrl.mul_sel   = MS_E_DT;
    unique case (state)
      ST_IDLE:      ctrl.idle = 1'b1;
      ST_MUL_E:     ctrl.mul_sel = MS_E_DT;
      ST_INT_ADD: begin
        ctrl.mul_sel = MS_KP_PE;
        ctrl.int_add = 1'b1;
      end
      ST_INT_CLAMP: begin
        ctrl.mul_sel   = MS_KD_VE;
        ctrl.int_clamp = 1'b1;
        ctrl.acc_load  = 1'b1;
      end
      ST_MUL_KI: begin
        ctrl.mul_sel = MS_KI_INT;
        ctrl.acc_add = 1'b1;
      end
      ST_SUM:       ctrl.acc_add = 1'b1;
      ST_OUT:       ctrl.out_load = !out_hold;
      default:      ctrl.idle = 1'b0;
    endcase
  end

endmodule

// File: hdl/pid_with_integral_and_output_clamp.sv
// Channel  Dir  Payload                                     Handshake
// cmd      in   action, positions, velocities, time_step    valid/ready
// res      out  control_out                                 valid/ready
// cfg      in   index, value                                valid/ready (always ready)
//
// A shared multiplier forms pe*dt, kp*pe, kd*ve and ki*integral in turn as
// the sequencer steps through MUL_E, INT_ADD, INT_CLAMP, MUL_KI, SUM and OUT;
// the next request is taken once it is back in idle. A clear request gives
// no result. cmd is ready only while the sequencer is idle; a result waiting
// on res stalls the sequencer in its last step.
// Reset (rst, synchronous) clears gains and integral, sets limits to full scale.
module pid_with_integral_and_output_clamp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic           clk,
  input logic           rst,
  pidc_stream_if.sink   cmd,
  pidc_stream_if.source res,
  pidc_stream_if.sink   cfg
);
  import pidc_pkg::*;

  localparam logic [30:0] DataCap = (DATA_WIDTH >= 32) ? LIMIT_MAX :
                                    31'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

  function automatic logic [30:0] eff_limit(logic [30:0] lim);
    return (lim > DataCap) ? DataCap : lim;
  endfunction

  // configuration registers
  logic signed [23:0] gain_p;
  logic signed [23:0] gain_d;
  logic signed [23:0] gain_i;
  logic        [30:0] integral_limit;
  logic        [30:0] out_limit;

  // working registers
  logic signed [ERR_W-1:0]  pos_err;
  logic signed [ERR_W-1:0]  vel_err;
  logic        [23:0]       dt;
  logic signed [31:0]       integral_acc;
  logic signed [ACC_W-1:0]  int_sum;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic                     out_valid;
  logic signed [31:0]       out_data;

  pidc_ctrl_t ctrl;

  logic              cmd_fire;
  logic              cfg_fire;
  logic              out_hold;
  logic [30:0]       ilim_eff;
  logic [30:0]       olim_eff;
  logic [30:0]       ilim_new;
  logic signed [ACC_W-1:0] acc_shift;
  logic signed [ACC_W-1:0] prod_shift;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cmd.ready = ctrl.idle;
  assign cfg.ready = 1'b1;
  assign out_hold  = out_valid && !res.ready;

  assign ilim_eff   = eff_limit(integral_limit);
  assign olim_eff   = eff_limit(out_limit);
  assign ilim_new   = eff_limit(cfg.data.value[30:0]);
  assign prod_shift = ACC_W'(prod >>> FRAC_BITS);
  assign acc_shift  = acc >>> FRAC_BITS;

  pidc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_fire && !cmd.data.action),
    .out_hold (out_hold),
    .ctrl     (ctrl)
  );

  pidc_mul u_mul (
    .clk      (clk),
    .sel      (ctrl.mul_sel),
    .pos_err  (pos_err),
    .vel_err  (vel_err),
    .integral (integral_acc),
    .dt       (dt),
    .kp       (gain_p),
    .kd       (gain_d),
    .ki       (gain_i),
    .prod     (prod)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_d         <= '0;
      gain_i         <= '0;
      integral_limit <= LIMIT_MAX;
      out_limit      <= LIMIT_MAX;
    end else if (cfg_fire) begin
      unique case (cfg.data.index)
        REG_GAIN_P:         gain_p <= cfg.data.value[23:0];
        REG_GAIN_D:         gain_d <= cfg.data.value[23:0];
        REG_GAIN_I:         gain_i <= cfg.data.value[23:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg.data.value[30:0];
        REG_OUTPUT_LIMIT:   out_limit <= cfg.data.value[30:0];
        default:            gain_p <= gain_p;
      endcase
    end
  end

  // integral state: clear, update clamp, re-clamp on limit writes
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
    end else begin
      priority if (cmd_fire && cmd.data.action) begin
        integral_acc <= '0;
      end else if (ctrl.int_clamp) begin
        integral_acc <= clamp_sym(int_sum, ilim_eff);
      end else if (cfg_fire && cfg.data.index == REG_INTEGRAL_LIMIT) begin
        integral_acc <= clamp_sym(ACC_W'(integral_acc), ilim_new);
      end else if (cfg_fire && cfg.data.index == REG_OUTPUT_LIMIT) begin
        integral_acc <= clamp_sym(ACC_W'(integral_acc), ilim_eff);
      end else begin
        integral_acc <= integral_acc;
      end
    end
  end

  // operand capture and accumulation
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      pos_err <= ERR_W'(cmd.data.target_position) - ERR_W'(cmd.data.measured_position);
      vel_err <= ERR_W'(cmd.data.target_velocity) - ERR_W'(cmd.data.measured_velocity);
      dt      <= cmd.data.time_step;
    end
    if (ctrl.int_add) begin
      int_sum <= ACC_W'(integral_acc) + prod_shift;
    end
    if (ctrl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data <= clamp_sym(acc_shift, olim_eff);
    end
  end

  assign res.valid            = out_valid;
  assign res.data.control_out = out_data;

`ifndef SYNTH
  // stored integral never exceeds its effective bound
  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    (integral_acc <= signed'({1'b0, ilim_eff})) &&
    (integral_acc >= -signed'({1'b0, ilim_eff})))
    else $error("integral outside its limit");

  // an update request starts the multiply sequence
  a_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && !cmd.data.action) |=> (ctrl.st == ST_MUL_E))
    else $error("update request did not start sequencer");

  // a clear request produces no result
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.data.action) |=> ctrl.idle && !ctrl.out_load)
    else $error("clear request left idle");

  // a result held on res is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ctrl.st == ST_OUT && out_hold) |-> !ctrl.out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

// File: test/pidc_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels, tracks the controller
// state and compares every result with the oldest predicted control value.
module pidc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_ready,
  input  pidc_pkg::pidc_cmd_t cmd_data,
  input  logic                res_valid,
  input  logic                res_ready,
  input  pidc_pkg::pidc_res_t res_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  pidc_pkg::pidc_cfg_t cfg_data,
  output int                  outstanding,
  output int                  errors
);
  import pidc_pkg::*;

  localparam int     FRAC      = 16;
  localparam longint FULL_SCALE = 64'sh7FFF_FFFF;

  // Controller state as seen from outside
  longint kp;
  longint kd;
  longint ki;
  longint integ_limit;
  longint out_limit;
  longint integ;

  logic signed [31:0] control_expected[$];
  logic signed [31:0] want;
  int                 fail_count;

  // Symmetric clamp; the limit is capped at full scale
  function automatic longint clamp_mag(input longint v, input longint lim);
    longint l;
    l = (lim < FULL_SCALE) ? lim : FULL_SCALE;
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // One control update: advance the integral, then form the clamped output
  function automatic logic signed [31:0] control_update(input pidc_cmd_t c);
    longint pos_err;
    longint vel_err;
    longint dt;
    longint sum;
    pos_err = longint'($signed(c.target_position)) - longint'($signed(c.measured_position));
    vel_err = longint'($signed(c.target_velocity)) - longint'($signed(c.measured_velocity));
    dt      = longint'(c.time_step);
    integ   = clamp_mag(integ + ((pos_err * dt) >>> FRAC), integ_limit);
    sum     = kp * pos_err + kd * vel_err + ki * integ;
    return 32'(clamp_mag(sum >>> FRAC, out_limit));
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      kp          = 0;
      kd          = 0;
      ki          = 0;
      integ_limit = longint'({1'b0, LIMIT_MAX});
      out_limit   = longint'({1'b0, LIMIT_MAX});
      integ       = 0;
      control_expected.delete();
    end else begin
      // results leaving the block
      if (res_valid && res_ready) begin
        if (control_expected.size() == 0) begin
          $display("%0t: control_out %0d arrived, expected nothing",
                   $time, res_data.control_out);
          fail_count++;
        end else begin
          want = control_expected.pop_front();
          if (res_data.control_out !== want) begin
            $display("%0t: control_out expected %0d, got %0d",
                     $time, want, res_data.control_out);
            fail_count++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_GAIN_P: kp = longint'($signed(cfg_data.value[23:0]));
          REG_GAIN_D: kd = longint'($signed(cfg_data.value[23:0]));
          REG_GAIN_I: ki = longint'($signed(cfg_data.value[23:0]));
          REG_INTEGRAL_LIMIT: begin
            integ_limit = longint'({1'b0, cfg_data.value[30:0]});
            integ       = clamp_mag(integ, integ_limit);
          end
          REG_OUTPUT_LIMIT: begin
            out_limit = longint'({1'b0, cfg_data.value[30:0]});
            integ     = clamp_mag(integ, integ_limit);
          end
          default: ;
        endcase
      end

      // requests entering the block
      if (cmd_valid && cmd_ready) begin
        if (cmd_data.action) begin
          integ = 0;
        end else begin
          control_expected.push_back(control_update(cmd_data));
        end
      end
    end
    outstanding <= control_expected.size();
    errors      <= fail_count;
  end

endmodule

// File: test/pid_with_integral_and_output_clamp_tb.sv
`timescale 1ns / 1ps

module pid_with_integral_and_output_clamp_tb;
  import pidc_pkg::*;

  localparam int SETTLE         = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 50;

  localparam logic [IDX_W-1:0] REG_SPARE = REG_OUTPUT_LIMIT + 3'd1;
  localparam logic [31:0]      LIM_FULL  = {1'b0, LIMIT_MAX};

  logic clk;
  logic rst;
  logic hold_req;
  int   outstanding;
  int   errors;
  int   burst_left;
  bit   allow_gaps;

  pidc_stream_if #(.payload_t(pidc_cmd_t)) cmd_if ();
  pidc_stream_if #(.payload_t(pidc_res_t)) res_if ();
  pidc_stream_if #(.payload_t(pidc_cfg_t)) cfg_if ();

  pid_with_integral_and_output_clamp dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  pidc_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_if.valid),
    .cmd_ready   (cmd_if.ready),
    .cmd_data    (cmd_if.data),
    .res_valid   (res_if.valid),
    .res_ready   (res_if.ready),
    .res_data    (res_if.data),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_data    (cfg_if.data),
    .outstanding (outstanding),
    .errors      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: too long without any handshake ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // Result side: rotating stall patterns, plus one long hold-off on request
  initial begin
    int cyc;
    bit held;
    cyc  = 0;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      cyc++;
      case ((cyc / 97) % 4)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= 1'($urandom_range(0, 1));
        2:       res_if.ready <= ($urandom_range(0, 3) == 0);
        default: res_if.ready <= ((cyc % 8) < 3);
      endcase
    end
  end

  function automatic pidc_cmd_t make_request(input logic act,
                                             input logic [31:0] mp, mv, tp, tv,
                                             input logic [23:0] dt);
    pidc_cmd_t c;
    c.action            = act;
    c.measured_position = mp;
    c.measured_velocity = mv;
    c.target_position   = tp;
    c.target_velocity   = tv;
    c.time_step         = dt;
    return c;
  endfunction

  // Position or velocity: mostly a few units, sometimes full range or extremes
  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    if (sel <= 2) return $urandom();
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(0, 7))
      0:       return 24'h0;
      1:       return 24'h01_0000;
      2:       return 24'hFF_FFFF;
      3, 4:    return 24'($urandom());
      default: return 24'($urandom_range(0, 32'h0002_0000));
    endcase
  endfunction

  // Gain: upper bits are don't-care, so full random words go in too
  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h007F_FFFF;
      1:       return 32'h0080_0000;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 7))
      0:       return LIM_FULL;
      1:       return 32'h0;
      2:       return $urandom();
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic pidc_cmd_t rand_request();
    return make_request($urandom_range(0, 9) == 0, rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_step());
  endfunction

  // Offer one request; bursts of random length with random gaps between
  task automatic send(input pidc_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (!allow_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    pidc_cfg_t w;
    w.index = idx;
    w.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [31:0] kp, kd, ki, il, ol);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_INTEGRAL_LIMIT, il);
    write_reg(REG_OUTPUT_LIMIT, ol);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering, wait for every result, then let a clear request finish
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int p;
    int k;
    rst          <= 1'b1;
    hold_req     <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    burst_left = 0;
    allow_gaps = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset gains are zero, but the integral still builds up to full scale
    send(make_request(1'b0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'h01_0000));
    send(make_request(1'b0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 24'hFF_FFFF));
    drain();

    configure(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, LIM_FULL, LIM_FULL);
    // zero error and zero dt: output is the integral term alone
    send(make_request(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0));
    // largest positive and negative errors on both paths
    send(make_request(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      24'hFF_FFFF));
    send(make_request(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      24'hFF_FFFF));
    // clear, with garbage in the ignored fields
    send(make_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      24'hFF_FFFF));
    // tiny negative products round toward minus infinity
    send(make_request(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 24'h00_0001));
    send(make_request(1'b0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 24'h00_0001));
    send(make_request(1'b0, 32'h0, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 24'h01_0000));
    send(make_request(1'b0, 32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 24'h0));
    send(make_request(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0));
    send(make_request(1'b0, 32'h0000_3039, 32'hFFFF_2BCF, 32'hFFFF_FC19, 32'h0000_0309,
                      24'h80_0000));
    // drive the integral to full scale before the limit shrinks
    send(make_request(1'b0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 24'hFF_FFFF));
    drain();

    // shrinking the integral limit clamps the stored integral at once
    configure(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h0003_0000, LIM_FULL);
    send(make_request(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0));
    send(make_request(1'b0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 24'h02_0000));
    drain();

    // zero limits: integral held at zero, output forced to zero
    configure(32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'h0, 32'h0);
    send(make_request(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      24'hFF_FFFF));
    send(make_request(1'b0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 24'h01_0000));
    drain();

    // extreme gains with a small output limit; spare index does nothing
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    configure(32'hFF7F_FFFF, 32'h0080_0000, 32'h0080_0000, LIM_FULL, 32'h0000_8000);
    send(make_request(1'b0, 32'h0, 32'h0, 32'h0000_0100, 32'h0, 24'h01_0000));
    send(make_request(1'b0, 32'h0, 32'h0000_0100, 32'h0, 32'h0, 24'h0));
    send(make_request(1'b0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 24'hFF_FFFF));
    drain();

    // Random phases, each with its own register settings
    for (p = 0; p < RAND_PHASES; p++) begin
      allow_gaps = (p % 3 != 1);
      if (p % 2 == 1) write_reg(REG_SPARE + 3'(p % 3), $urandom());
      configure(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
      // long result hold-off while requests keep coming
      if (p == 2) hold_req <= 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send(rand_request());
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
